// ===== hdl/weekday_count_between_dates_core_macros.svh =====
// assertion macros for the weekday count core
// used by weekday_count_between_dates_core; empty bodies when SYNTHESIS is set
`ifndef WEEKDAY_COUNT_BETWEEN_DATES_CORE_MACROS_SVH
`define WEEKDAY_COUNT_BETWEEN_DATES_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WDC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define WDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define WDC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define WDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/wdcnt_pkg.sv =====
// shared types, constants and calendar functions of the weekday count core
// no dependencies; imported by wdcnt_seq, wdcnt_dp and the top level
package wdcnt_pkg;

   localparam int YEAR_W     = 12;
   localparam int MONTH_W    = 4;
   localparam int DAY_W      = 5;
   localparam int SERIAL_W   = 21;
   localparam int COUNT_W    = 20;
   localparam int Q100_W     = 6;
   localparam int Q7_W       = 19;
   localparam int PC_W       = 5;
   localparam int MASK_W     = 7;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [YEAR_W-1:0]  YEAR_MAX  = 12'd2999;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

   // y / 100 = (y * RECIP100) >> RECIP100_SHIFT for 12-bit y
   localparam logic [12:0] RECIP100       = 13'd5243;
   localparam int          RECIP100_SHIFT = 19;
   localparam int          YPROD_W        = YEAR_W + 13;
   localparam logic [6:0]  YEARS_PER_CENTURY = 7'd100;
   // x / 7 = (x * RECIP7) >> RECIP7_SHIFT for 21-bit x
   localparam logic [21:0] RECIP7         = 22'd2396746;
   localparam int          RECIP7_SHIFT   = 24;
   localparam int          DPROD_W        = SERIAL_W + 22;

   localparam logic [8:0] DAYS_PER_YEAR  = 9'd365;
   localparam logic [2:0] DAYS_PER_WEEK  = 3'd7;
   localparam logic [2:0] SUNDAY         = 3'd0;
   localparam logic [2:0] SATURDAY       = 3'd6;
   // weekday of day serial zero
   localparam logic [2:0] WEEKDAY_OFFSET = 3'd2;

   localparam logic [MASK_W-1:0] WEEKEND_MASK_RESET = 7'd65;
   localparam logic              CSR_IDX_WEEKEND_MASK = 1'b0;

   // operand selects carried in the control word
   localparam logic SEL_START  = 1'b0;
   localparam logic SEL_END    = 1'b1;
   localparam logic SEL_SPAN   = 1'b0;
   localparam logic SEL_SERIAL = 1'b1;

   typedef enum logic [3:0] {
      OP_LEAP_MUL,
      OP_CHECK,
      OP_YADJ_MUL,
      OP_SER_A,
      OP_SER_B,
      OP_SPAN,
      OP_MUL7,
      OP_REM7,
      OP_BULK,
      OP_TAIL,
      OP_FINISH,
      OP_BAD,
      OP_ZERO
   } op_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_BAD,
      JMP_LATE,
      JMP_TAIL
   } jmp_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef struct packed {
      op_type            op;
      logic              sel;
      jmp_type           jmp;
      logic [PC_W-1:0]   target;
   } ucode_type;

   typedef struct packed {
      logic   load;
      logic   exec;
      logic   emit;
      op_type op;
      logic   sel;
   } ctrl_type;

   typedef struct packed {
      logic bad;
      logic late;
      logic tail_more;
   } status_type;

   // last field in the lowest bits
   typedef struct packed {
      logic [DAY_W-1:0]   end_day;
      logic [MONTH_W-1:0] end_month;
      logic [YEAR_W-1:0]  end_year;
      logic [DAY_W-1:0]   start_day;
      logic [MONTH_W-1:0] start_month;
      logic [YEAR_W-1:0]  start_year;
   } req_type;

   typedef struct packed {
      logic               bad_date;
      logic [COUNT_W-1:0] workday_count;
   } rsp_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // days before the month in a year that starts in march
   function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
      logic [8:0] off;
      case (m)
         4'd3:    off = 9'd0;
         4'd4:    off = 9'd31;
         4'd5:    off = 9'd61;
         4'd6:    off = 9'd92;
         4'd7:    off = 9'd122;
         4'd8:    off = 9'd153;
         4'd9:    off = 9'd184;
         4'd10:   off = 9'd214;
         4'd11:   off = 9'd245;
         4'd12:   off = 9'd275;
         4'd1:    off = 9'd306;
         4'd2:    off = 9'd337;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

endpackage

// ===== hdl/weekday_count_between_dates_core.sv =====
// Counts the days from a start date to an end date, both included, whose weekday is not
// excluded by weekend_mask (reset value: Saturday and Sunday). One transaction is worked on
// at a time by a 20-step microcode program: a valid pair runs 16 fixed steps, one to six steps
// over the leftover days of the last partial week and one to emit; a pair with an invalid date
// or a start after the end jumps to its own emit step. The result sits in an output register,
// so the next transaction is accepted in the cycle after the result is produced even while it
// waits on rsp_tready.
// Depends on wdcnt_pkg, wdcnt_seq, wdcnt_dp and weekday_count_between_dates_core_macros.svh.
`include "weekday_count_between_dates_core_macros.svh"
module weekday_count_between_dates_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // start_year, start_month, start_day, end_year, end_month, end_day from bit 0 up
   input  logic [wdcnt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // workday_count from bit 0 up
   output logic [wdcnt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // bad_date
   output logic                                rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wdcnt_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [wdcnt_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [wdcnt_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import wdcnt_pkg::*;

   logic [MASK_W-1:0]  weekend_mask_ff, weekend_mask_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               csr_write;
   logic               out_free;
   logic               idle;
   ctrl_type           ctrl;
   status_type         status;
   rsp_type            result;
   req_type            req;

   assign req = req_tdata[$bits(req_type)-1:0];

   wdcnt_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_tvalid),
      .out_free (out_free),
      .status   (status),
      .idle     (idle),
      .ctrl     (ctrl)
   );

   wdcnt_dp u_dp (
      .clock        (clock),
      .ctrl         (ctrl),
      .req          (req),
      .weekend_mask (weekend_mask_ff),
      .status       (status),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         weekend_mask_ff <= WEEKEND_MASK_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         weekend_mask_ff <= weekend_mask_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_comb begin
      csr_pready = 1'b1;
      csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
      weekend_mask_in = weekend_mask_ff;
      if (csr_write && (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_WEEKEND_MASK)) begin
         weekend_mask_in = csr_pwdata[MASK_W-1:0];
      end
      csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_WEEKEND_MASK) ?
                   CSR_DATA_W'(weekend_mask_ff) : '0;

      out_free     = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      if (ctrl.exec && ctrl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end

      req_tready = idle;
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = RSP_TDATA_W'(rsp_ff.workday_count);
      rsp_tuser  = rsp_ff.bad_date;
   end

   `WDC_ASSERT_IMPL(a_bad_has_zero_count, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "bad date transaction with nonzero count")
   `WDC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "accepted a transaction while busy")
   `WDC_ASSERT_IMPL(a_emit_needs_room, clock, reset, ctrl.exec && ctrl.emit, !rsp_valid_ff || rsp_tready, "result overwrote a pending transaction")
   `WDC_ASSERT_NEXT(a_mask_write, clock, reset, csr_write && (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_WEEKEND_MASK), weekend_mask_ff == $past(csr_pwdata[MASK_W-1:0]), "weekend mask write lost")

endmodule

// ===== hdl/wdcnt_seq.sv =====
// microcode sequencer: program rom, step counter and conditional jumps
// depends on wdcnt_pkg; drives wdcnt_dp through a ctrl_type word
module wdcnt_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   out_free,
   input  wdcnt_pkg::status_type  status,
   output logic                   idle,
   output wdcnt_pkg::ctrl_type    ctrl
);
   import wdcnt_pkg::*;

   localparam logic [PC_W-1:0] STEP_FIRST = 5'd0;
   localparam logic [PC_W-1:0] STEP_TAIL  = 5'd16;
   localparam logic [PC_W-1:0] STEP_BAD   = 5'd18;
   localparam logic [PC_W-1:0] STEP_ZERO  = 5'd19;

   function automatic ucode_type ucode_word(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         5'd0:    w = '{OP_LEAP_MUL, SEL_START,  JMP_NONE, STEP_FIRST};
         5'd1:    w = '{OP_CHECK,    SEL_START,  JMP_NONE, STEP_FIRST};
         5'd2:    w = '{OP_LEAP_MUL, SEL_END,    JMP_NONE, STEP_FIRST};
         5'd3:    w = '{OP_CHECK,    SEL_END,    JMP_NONE, STEP_FIRST};
         5'd4:    w = '{OP_YADJ_MUL, SEL_START,  JMP_BAD,  STEP_BAD};
         5'd5:    w = '{OP_SER_A,    SEL_START,  JMP_NONE, STEP_FIRST};
         5'd6:    w = '{OP_SER_B,    SEL_START,  JMP_NONE, STEP_FIRST};
         5'd7:    w = '{OP_YADJ_MUL, SEL_END,    JMP_NONE, STEP_FIRST};
         5'd8:    w = '{OP_SER_A,    SEL_END,    JMP_NONE, STEP_FIRST};
         5'd9:    w = '{OP_SER_B,    SEL_END,    JMP_NONE, STEP_FIRST};
         5'd10:   w = '{OP_SPAN,     SEL_START,  JMP_LATE, STEP_ZERO};
         5'd11:   w = '{OP_MUL7,     SEL_SPAN,   JMP_NONE, STEP_FIRST};
         5'd12:   w = '{OP_REM7,     SEL_SPAN,   JMP_NONE, STEP_FIRST};
         5'd13:   w = '{OP_MUL7,     SEL_SERIAL, JMP_NONE, STEP_FIRST};
         5'd14:   w = '{OP_REM7,     SEL_SERIAL, JMP_NONE, STEP_FIRST};
         5'd15:   w = '{OP_BULK,     SEL_START,  JMP_NONE, STEP_FIRST};
         5'd16:   w = '{OP_TAIL,     SEL_START,  JMP_TAIL, STEP_TAIL};
         5'd17:   w = '{OP_FINISH,   SEL_START,  JMP_NONE, STEP_FIRST};
         5'd18:   w = '{OP_BAD,      SEL_START,  JMP_NONE, STEP_FIRST};
         5'd19:   w = '{OP_ZERO,     SEL_START,  JMP_NONE, STEP_FIRST};
         default: w = '{OP_BAD,      SEL_START,  JMP_NONE, STEP_FIRST};
      endcase
      return w;
   endfunction

   seq_state_type   state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   ucode_type       word;
   logic            emit;
   logic            take;
   logic            exec;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         pc_ff    <= STEP_FIRST;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   always_comb begin
      word     = ucode_word(pc_ff);
      emit     = word.op inside {OP_FINISH, OP_BAD, OP_ZERO};
      exec     = 1'b0;
      state_in = state_ff;
      pc_in    = pc_ff;
      case (word.jmp)
         JMP_BAD:  take = status.bad;
         JMP_LATE: take = status.late;
         JMP_TAIL: take = status.tail_more;
         default:  take = 1'b0;
      endcase
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_RUN;
               pc_in    = STEP_FIRST;
            end
         end
         SEQ_RUN: begin
            exec = !emit || out_free;
            if (exec) begin
               if (emit) begin
                  state_in = SEQ_IDLE;
               end else if (take) begin
                  pc_in = word.target;
               end else begin
                  pc_in = pc_ff + 5'd1;
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
      idle      = (state_ff == SEQ_IDLE);
      ctrl.load = idle && start;
      ctrl.exec = exec;
      ctrl.emit = emit;
      ctrl.op   = word.op;
      ctrl.sel  = word.sel;
   end

endmodule

// ===== hdl/wdcnt_dp.sv =====
// datapath of the weekday count core: date check, day serials, divide by seven, tally
// depends on wdcnt_pkg; controlled by wdcnt_seq one step per cycle unless stalled
module wdcnt_dp (
   input  logic                          clock,
   input  wdcnt_pkg::ctrl_type           ctrl,
   input  wdcnt_pkg::req_type            req,
   input  logic [wdcnt_pkg::MASK_W-1:0]  weekend_mask,
   output wdcnt_pkg::status_type         status,
   output wdcnt_pkg::rsp_type            result
);
   import wdcnt_pkg::*;

   req_type               date_ff, date_in;
   logic [Q100_W-1:0]     q100_ff, q100_in;
   logic                  bad_ff, bad_in;
   logic [SERIAL_W-1:0]   acc_ff, acc_in;
   logic [SERIAL_W-1:0]   s_ff, s_in;
   logic [SERIAL_W-1:0]   e_ff, e_in;
   logic [SERIAL_W-1:0]   n_ff, n_in;
   logic [Q7_W-1:0]       q7_ff, q7_in;
   logic [Q7_W-1:0]       qn_ff, qn_in;
   logic [2:0]            left_ff, left_in;
   logic [2:0]            wd_ff, wd_in;
   logic [SERIAL_W-1:0]   count_ff, count_in;

   logic [YEAR_W-1:0]     y_sel, y_adj, y_mul;
   logic [MONTH_W-1:0]    m_sel;
   logic [DAY_W-1:0]      d_sel;
   logic [YPROD_W-1:0]    prod_y;
   logic                  leap;
   logic                  date_ok;
   logic [SERIAL_W-1:0]   serial_sum;
   logic [SERIAL_W-1:0]   div_src;
   logic [DPROD_W-1:0]    prod7;
   logic [SERIAL_W-1:0]   rem_full;
   logic [3:0]            wd_raw;
   logic [2:0]            per_week;

   always_ff @(posedge clock) begin
      date_ff  <= date_in;
      q100_ff  <= q100_in;
      bad_ff   <= bad_in;
      acc_ff   <= acc_in;
      s_ff     <= s_in;
      e_ff     <= e_in;
      n_ff     <= n_in;
      q7_ff    <= q7_in;
      qn_ff    <= qn_in;
      left_ff  <= left_in;
      wd_ff    <= wd_in;
      count_ff <= count_in;
   end

   always_comb begin
      y_sel = (ctrl.sel == SEL_END) ? date_ff.end_year  : date_ff.start_year;
      m_sel = (ctrl.sel == SEL_END) ? date_ff.end_month : date_ff.start_month;
      d_sel = (ctrl.sel == SEL_END) ? date_ff.end_day   : date_ff.start_day;
      // january and february count with the previous year
      y_adj = (m_sel <= MONTH_FEB) ? y_sel - 12'd1 : y_sel;
      y_mul = (ctrl.op == OP_LEAP_MUL) ? y_sel : y_adj;
      prod_y = YPROD_W'(y_mul) * YPROD_W'(RECIP100);

      leap = (y_sel[1:0] == 2'b00) &&
             (((13'(q100_ff) * 13'(YEARS_PER_CENTURY)) != 13'(y_sel)) ||
              (q100_ff[1:0] == 2'b00));
      date_ok = (y_sel != '0) && (y_sel <= YEAR_MAX) &&
                (m_sel != '0) && (m_sel <= MONTH_DEC) &&
                (d_sel != '0) && (d_sel <= month_days(m_sel, leap));

      serial_sum = acc_ff - SERIAL_W'(q100_ff) + SERIAL_W'(q100_ff >> 2) +
                   SERIAL_W'(month_offset(m_sel)) + SERIAL_W'(d_sel);

      div_src  = (ctrl.sel == SEL_SERIAL) ? s_ff : n_ff;
      prod7    = DPROD_W'(div_src) * DPROD_W'(RECIP7);
      rem_full = div_src - SERIAL_W'(q7_ff) * SERIAL_W'(DAYS_PER_WEEK);
      wd_raw   = 4'(rem_full[2:0]) + 4'(WEEKDAY_OFFSET);
      per_week = 3'($countones(~weekend_mask));

      date_in  = date_ff;
      q100_in  = q100_ff;
      bad_in   = bad_ff;
      acc_in   = acc_ff;
      s_in     = s_ff;
      e_in     = e_ff;
      n_in     = n_ff;
      q7_in    = q7_ff;
      qn_in    = qn_ff;
      left_in  = left_ff;
      wd_in    = wd_ff;
      count_in = count_ff;

      if (ctrl.load) begin
         date_in = req;
      end else if (ctrl.exec) begin
         case (ctrl.op)
            OP_LEAP_MUL, OP_YADJ_MUL: begin
               q100_in = prod_y[RECIP100_SHIFT +: Q100_W];
            end
            OP_CHECK: begin
               bad_in = (ctrl.sel == SEL_START) ? !date_ok : (bad_ff || !date_ok);
            end
            OP_SER_A: begin
               acc_in = SERIAL_W'(y_adj) * SERIAL_W'(DAYS_PER_YEAR) + SERIAL_W'(y_adj >> 2);
            end
            OP_SER_B: begin
               if (ctrl.sel == SEL_END) begin
                  e_in = serial_sum;
               end else begin
                  s_in = serial_sum;
               end
            end
            OP_SPAN: begin
               n_in = e_ff - s_ff + SERIAL_W'(1);
            end
            OP_MUL7: begin
               q7_in = prod7[RECIP7_SHIFT +: Q7_W];
            end
            OP_REM7: begin
               if (ctrl.sel == SEL_SPAN) begin
                  qn_in   = q7_ff;
                  left_in = rem_full[2:0];
               end else begin
                  wd_in = (wd_raw >= 4'(DAYS_PER_WEEK)) ? 3'(wd_raw - 4'(DAYS_PER_WEEK))
                                                        : wd_raw[2:0];
               end
            end
            OP_BULK: begin
               count_in = SERIAL_W'(qn_ff) * SERIAL_W'(per_week);
            end
            OP_TAIL: begin
               if (left_ff != 3'd0) begin
                  count_in = count_ff + SERIAL_W'(!weekend_mask[wd_ff]);
                  wd_in    = (wd_ff == SATURDAY) ? SUNDAY : wd_ff + 3'd1;
                  left_in  = left_ff - 3'd1;
               end
            end
            default: begin
            end
         endcase
      end

      status.bad       = bad_ff;
      status.late      = (s_ff > e_ff);
      status.tail_more = (left_ff > 3'd1);

      case (ctrl.op)
         OP_FINISH: begin
            result.bad_date      = 1'b0;
            result.workday_count = (count_ff > SERIAL_W'(COUNT_MAX)) ? COUNT_MAX
                                                                     : count_ff[COUNT_W-1:0];
         end
         OP_BAD: begin
            result.bad_date      = 1'b1;
            result.workday_count = '0;
         end
         default: begin
            result.bad_date      = 1'b0;
            result.workday_count = '0;
         end
      endcase
   end

endmodule

// ===== dv/weekday_count_between_dates_core_tb.sv =====
// self-checking testbench for weekday_count_between_dates_core: date pairs in on req_,
// workday counts out on rsp_, weekend mask set over the csr_ register port
// depends on wdcnt_pkg and the core; predicts each count with its own calendar arithmetic
module weekday_count_between_dates_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wdcnt_pkg::*;

   localparam int LAST_YEAR = 2999;
   localparam int FULL_COUNT = 1048575;
   localparam logic [CSR_ADDR_W-1:0] MASK_ADDR = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = 3'd4;
   localparam int HOLD_CYCLES = 150;
   localparam int IDLE_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } cal_date_type;

   class workday_scoreboard;
      rsp_type expected_q[$];
      logic [MASK_W-1:0] mask;
      int errors;
      int checked;
      int bad_seen;
      int saturated;

      function new();
         mask = 7'b1000001;
         errors = 0;
         checked = 0;
         bad_seen = 0;
         saturated = 0;
      endfunction

      static function bit is_leap(int y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      static function int month_length(int y, int m);
         int len;
         case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = is_leap(y) ? 29 : 28;
            default:               len = 0;
         endcase
         return len;
      endfunction

      static function bit date_valid(cal_date_type d);
         int y;
         int dd;
         y = int'(d.year);
         dd = int'(d.day);
         if (y < 1 || y > LAST_YEAR) return 1'b0;
         return dd >= 1 && dd <= month_length(y, int'(d.month));
      endfunction

      // march-based day number, increasing with the date
      static function int day_number(cal_date_type d);
         int y;
         int m;
         int mp;
         y = int'(d.year);
         m = int'(d.month);
         if (m <= 2) begin
            y = y - 1;
            mp = m + 9;
         end else begin
            mp = m - 3;
         end
         return 365 * y + y / 4 - y / 100 + y / 400 + (153 * mp + 2) / 5 + int'(d.day);
      endfunction

      // 0 sunday .. 6 saturday
      static function int weekday_of(cal_date_type d);
         int a;
         int y;
         int m;
         int mo;
         mo = int'(d.month);
         a = (14 - mo) / 12;
         y = int'(d.year) - a;
         m = mo + 12 * a - 2;
         return (int'(d.day) + y + y / 4 - y / 100 + y / 400 + (31 * m) / 12) % 7;
      endfunction

      function void note_request(req_type r);
         cal_date_type s;
         cal_date_type e;
         rsp_type want;
         int n;
         int cnt;
         int w;
         s = {r.start_day, r.start_month, r.start_year};
         e = {r.end_day, r.end_month, r.end_year};
         want = '0;
         if (!date_valid(s) || !date_valid(e)) begin
            want.bad_date = 1'b1;
            bad_seen++;
         end else if (day_number(s) <= day_number(e)) begin
            n = day_number(e) - day_number(s) + 1;
            cnt = (n / 7) * (7 - $countones(mask));
            w = weekday_of(s);
            for (int i = 0; i < n % 7; i++) begin
               if (!mask[w]) cnt++;
               w = (w + 1) % 7;
            end
            if (cnt > FULL_COUNT) begin
               cnt = FULL_COUNT;
               saturated++;
            end
            want.workday_count = cnt[COUNT_W-1:0];
         end
         expected_q.push_back(want);
      endfunction

      function void compare(string field, longint want, longint got);
         if (want != got) begin
            errors++;
            $error("%s: expected %0d, got %0d", field, want, got);
         end
      endfunction

      function void check_response(logic [COUNT_W-1:0] count, logic bad);
         rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $error("unexpected transaction: workday_count %0d, bad_date %0d", count, bad);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         compare("workday_count", longint'(want.workday_count), longint'(count));
         compare("bad_date", longint'(want.bad_date), longint'(bad));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   logic steady = 1'b0;
   logic hold_ask = 1'b0;
   logic hold_taken = 1'b0;
   int hold_left = 0;
   int sent = 0;
   int mask_settings = 1;
   workday_scoreboard sb;

   weekday_count_between_dates_core dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   // result side: check each transaction, random back-pressure, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata[COUNT_W-1:0], rsp_tuser);
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (hold_ask && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 25);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) quiet = 0;
         else quiet++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   function automatic cal_date_type mkdate(int y, int m, int d);
      cal_date_type r;
      r.year = y[YEAR_W-1:0];
      r.month = m[MONTH_W-1:0];
      r.day = d[DAY_W-1:0];
      return r;
   endfunction

   function automatic cal_date_type any_date(int ylo, int yhi);
      int y;
      int m;
      y = $urandom_range(yhi, ylo);
      m = $urandom_range(12, 1);
      return mkdate(y, m, $urandom_range(workday_scoreboard::month_length(y, m), 1));
   endfunction

   task automatic send_pair(cal_date_type s, cal_date_type e);
      req_type r;
      r = {e, s};
      while (!steady && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {{(REQ_TDATA_W - $bits(req_type)){1'b0}}, r};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(r);
      sent++;
   endtask

   task automatic send_random();
      cal_date_type s;
      cal_date_type e;
      int pick;
      int y;
      pick = $urandom_range(0, 99);
      s = any_date(1, LAST_YEAR);
      if (pick < 25) begin
         e = mkdate(int'(s.year), int'(s.month),
                    $urandom_range(workday_scoreboard::month_length(int'(s.year),
                                                                    int'(s.month)), 1));
      end else if (pick < 65) begin
         y = int'(s.year) + int'($urandom_range(0, 2));
         if (y > LAST_YEAR) y = LAST_YEAR;
         e = any_date(y, y);
      end else if (pick < 80) begin
         e = any_date(1, LAST_YEAR);
      end else if (pick < 90) begin
         e = any_date(int'(s.year), LAST_YEAR);
         case ($urandom_range(0, 5))
            0: s.year = YEAR_W'($urandom_range(4095, 0));
            1: s.month = MONTH_W'($urandom_range(15, 0));
            2: s.day = DAY_W'($urandom_range(31, 0));
            3: e.year = YEAR_W'($urandom_range(4095, 0));
            4: e.month = MONTH_W'($urandom_range(15, 0));
            default: e.day = DAY_W'($urandom_range(31, 0));
         endcase
      end else begin
         s = cal_date_type'(21'($urandom));
         e = cal_date_type'(21'($urandom));
      end
      send_pair(s, e);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == MASK_ADDR) begin
         sb.mask = data[MASK_W-1:0];
         mask_settings++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_mask_readback();
      logic [CSR_DATA_W-1:0] data;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= MASK_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      sb.compare("weekend_mask", longint'(sb.mask), longint'(data));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mask(logic [CSR_DATA_W-1:0] data);
      csr_write(MASK_ADDR, data);
      check_mask_readback();
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      steady <= 1'b1;
      @(posedge clock);

      // reset mask: directed pairs with no idling on either side, then random pairs with idling
      send_pair(mkdate(1, 1, 1), mkdate(LAST_YEAR, 12, 31));
      send_pair(mkdate(2024, 3, 15), mkdate(2024, 3, 15));
      send_pair(mkdate(2024, 3, 16), mkdate(2024, 3, 15));
      send_pair(mkdate(1, 1, 1), mkdate(1, 1, 7));
      send_pair(mkdate(1, 1, 1), mkdate(1, 1, 1));
      send_pair(mkdate(LAST_YEAR, 12, 31), mkdate(LAST_YEAR, 12, 31));
      send_pair(mkdate(2000, 2, 29), mkdate(2000, 3, 1));
      send_pair(mkdate(2400, 2, 29), mkdate(2400, 3, 6));
      send_pair(mkdate(1900, 2, 29), mkdate(1900, 3, 1));
      send_pair(mkdate(2023, 2, 1), mkdate(2023, 2, 29));
      send_pair(mkdate(2100, 2, 28), mkdate(2100, 2, 29));
      send_pair(mkdate(1999, 12, 31), mkdate(2000, 1, 1));
      send_pair(mkdate(0, 5, 5), mkdate(10, 5, 5));
      send_pair(mkdate(2990, 5, 5), mkdate(3000, 1, 1));
      send_pair(mkdate(4095, 15, 31), mkdate(4095, 15, 31));
      send_pair(mkdate(2020, 0, 10), mkdate(2020, 5, 10));
      send_pair(mkdate(2020, 1, 10), mkdate(2020, 13, 10));
      send_pair(mkdate(2020, 1, 0), mkdate(2020, 1, 10));
      send_pair(mkdate(2021, 4, 31), mkdate(2021, 5, 1));
      send_pair(mkdate(2021, 6, 1), mkdate(2021, 6, 31));
      send_pair(mkdate(1582, 10, 4), mkdate(1582, 10, 15));
      steady <= 1'b0;
      repeat (20) send_random();
      drain();

      // every day counted, long receiver hold-off while requests keep coming
      set_mask(32'd0);
      send_pair(mkdate(1, 1, 1), mkdate(LAST_YEAR, 12, 31));
      send_pair(mkdate(1, 3, 1), mkdate(LAST_YEAR, 12, 31));
      hold_ask <= 1'b1;
      repeat (20) send_random();
      drain();

      // every day excluded
      set_mask(32'd127);
      send_pair(mkdate(1, 1, 1), mkdate(LAST_YEAR, 12, 31));
      repeat (15) send_random();
      drain();

      // unmapped address must leave the mask alone
      csr_write(SPARE_ADDR, $urandom);
      check_mask_readback();

      repeat (3) begin
         set_mask($urandom);
         send_pair(mkdate(1, 1, 1), mkdate(LAST_YEAR, 12, 31));
         repeat (15) send_random();
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d date pairs sent, %0d results checked under %0d weekend mask settings",
               sent, sb.checked, mask_settings);
      $display("%0d pairs with an invalid date, %0d counts at saturation",
               sb.bad_seen, sb.saturated);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

// ===== weekday_count_between_dates_core.f =====
+incdir+hdl
hdl/wdcnt_pkg.sv
hdl/wdcnt_seq.sv
hdl/wdcnt_dp.sv
hdl/weekday_count_between_dates_core.sv
dv/weekday_count_between_dates_core_tb.sv
